### rtl/console_line_editor_unit_macros.svh
// ----------------------------------------------------------------------------
// Console line editor assertion macros
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_LINE_EDITOR_UNIT_MACROS_SVH
`define CONSOLE_LINE_EDITOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CLE_ASSERT(lbl, prop, msg)
`define CLE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/cle_pkg.sv
// ----------------------------------------------------------------------------
// Console line editor package
// Ring geometry, key codes, result kinds, controller states and index math.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int RING_DEPTH     = 128;
  localparam int TERMINAL_COUNT = 6;

  localparam int IDX_MOD     = 2 * RING_DEPTH;
  localparam int IDX_W       = $clog2(IDX_MOD);
  localparam int IDXP_W      = IDX_W + 1;
  localparam int SLOT_W      = $clog2(RING_DEPTH);
  localparam int TERM_W      = 3;
  localparam int TSEL_W      = (TERMINAL_COUNT > 1) ? $clog2(TERMINAL_COUNT) : 1;
  localparam int STORE_DEPTH = TERMINAL_COUNT * RING_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [IDXP_W-1:0] idxp_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [TERM_W-1:0] term_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam logic [7:0] KEY_NUL       = 8'd0;
  localparam logic [7:0] KEY_CTRL_D    = 8'd4;
  localparam logic [7:0] KEY_CTRL_H    = 8'd8;
  localparam logic [7:0] KEY_LF        = 8'd10;
  localparam logic [7:0] KEY_CR        = 8'd13;
  localparam logic [7:0] KEY_CTRL_P    = 8'd16;
  localparam logic [7:0] KEY_CTRL_U    = 8'd21;
  localparam logic [7:0] KEY_DEL       = 8'd127;
  localparam logic [7:0] KEY_ALT_FIRST = 8'd149;
  localparam logic [7:0] KEY_ALT_LAST  = 8'd154;
  localparam logic [7:0] KEY_HIST_UP   = 8'hE2;
  localparam logic [7:0] KEY_HIST_DN   = 8'hE3;

  typedef enum logic {
    OP_KEY,
    OP_READ
  } op_e;

  typedef enum logic [2:0] {
    KIND_DROP,
    KIND_ECHO,
    KIND_ERASE,
    KIND_SWITCH,
    KIND_DUMP,
    KIND_RD_BYTE,
    KIND_RD_EMPTY,
    KIND_EOF
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ_WAIT,
    ST_KILL_WAIT
  } state_e;

  typedef struct packed {
    logic       wr_en;
    addr_t      wr_addr;
    logic [7:0] wr_data;
    logic       rd_en;
    addr_t      rd_addr;
  } ram_req_t;

  function automatic idx_t idx_inc(idx_t a);
    return (a == idx_t'(IDX_MOD - 1)) ? '0 : a + idx_t'(1);
  endfunction

  function automatic idx_t idx_dec(idx_t a);
    return (a == '0) ? idx_t'(IDX_MOD - 1) : a - idx_t'(1);
  endfunction

  function automatic idx_t idx_diff(idx_t a, idx_t b);
    idxp_t wide;
    if (a >= b) begin
      wide = idxp_t'(a) - idxp_t'(b);
    end else begin
      wide = idxp_t'(a) + idxp_t'(IDX_MOD) - idxp_t'(b);
    end
    return wide[IDX_W-1:0];
  endfunction

  function automatic addr_t addr_of(term_t t, idx_t a);
    slot_t s;
    if (a >= idx_t'(RING_DEPTH)) begin
      s = slot_t'(a - idx_t'(RING_DEPTH));
    end else begin
      s = a[SLOT_W-1:0];
    end
    return addr_t'(int'(t) * RING_DEPTH + int'(s));
  endfunction

endpackage

### rtl/cle_line_ram.sv
// ----------------------------------------------------------------------------
// Console line editor line store
// One write port and one registered read port over all terminal rings.
// ----------------------------------------------------------------------------
module cle_line_ram (
  input  logic              clk_i,
  input  cle_pkg::ram_req_t req_i,
  output logic [7:0]        rd_data_o
);
  import cle_pkg::*;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/console_line_editor_unit.sv
// ----------------------------------------------------------------------------
// Console line editor
// Canonical line editing over one input ring per terminal.
//
//   channel  dir  tdata (low bit up)                      tuser
//   s_axis   in   key_code[7:0] first_of_read[8] pad      operation[0]
//   m_axis   out  data[7:0] erase_count[15:8]             kind[2:0]
//                 terminal[18:16] line_ready[19] pad
//
// An item is accepted, then decoded; a read that finds a committed byte
// also waits on the line store read port. Ctrl-U walks back one byte per
// cycle through that port until a line feed or the commit point.
// Reset clears all indices and selects terminal 0; the store is not cleared.
// A stalled result holds in the output register; input is taken once it
// drains.
// ----------------------------------------------------------------------------
`include "console_line_editor_unit_macros.svh"

module console_line_editor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // key_code, first_of_read
  input  logic [0:0]  s_axis_tuser_i,  // operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // data, erase_count, terminal, line_ready
  output logic [2:0]  m_axis_tuser_o   // kind
);
  import cle_pkg::*;

  state_e state_q, state_d;

  op_e        op_q;
  logic [7:0] key_q;
  logic       first_q;

  idx_t  read_idx_q   [TERMINAL_COUNT];
  idx_t  commit_idx_q [TERMINAL_COUNT];
  idx_t  edit_idx_q   [TERMINAL_COUNT];
  term_t active_q, active_d;
  logic [7:0] cnt_q, cnt_d;

  idx_t read_idx_d, commit_idx_d, edit_idx_d;
  logic read_we, commit_we, edit_we;

  logic       out_valid_q, out_valid_d;
  kind_e      out_kind_q, out_kind_d;
  logic [7:0] out_data_q, out_data_d;
  logic [7:0] out_cnt_q, out_cnt_d;
  term_t      out_term_q, out_term_d;
  logic       out_rdy_q, out_rdy_d;

  ram_req_t   ram_req;
  logic [7:0] ram_rd_data;

  logic [TSEL_W-1:0] tsel;
  idx_t cur_read, cur_commit, cur_edit;
  logic in_beat;
  logic is_alt, need_read, need_kill, kill_more;

  assign tsel       = active_q[TSEL_W-1:0];
  assign cur_read   = read_idx_q[tsel];
  assign cur_commit = commit_idx_q[tsel];
  assign cur_edit   = edit_idx_q[tsel];

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  assign is_alt    = (key_q >= KEY_ALT_FIRST) && (key_q <= KEY_ALT_LAST);
  assign need_read = (op_q == OP_READ) && (cur_read != cur_commit);
  assign need_kill = (op_q == OP_KEY) && (key_q == KEY_CTRL_U) && (cur_edit != cur_commit);
  assign kill_more = (ram_rd_data != KEY_LF) && (idx_dec(cur_edit) != cur_commit);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (need_read) state_d = ST_READ_WAIT;
        else if (need_kill)     state_d = ST_KILL_WAIT;
        else                    state_d = ST_IDLE;
      end
      ST_READ_WAIT: state_d = ST_IDLE;
      ST_KILL_WAIT: begin
        if (!kill_more) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    logic       load;
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] cnt;
    logic       rdy;
    logic [7:0] alt_tgt;
    logic [7:0] ch;
    idx_t       nxt;

    load         = 1'b0;
    kind         = KIND_DROP;
    data         = '0;
    cnt          = '0;
    rdy          = 1'b0;
    alt_tgt      = key_q - KEY_ALT_FIRST;
    ch           = (key_q == KEY_CR) ? KEY_LF : key_q;
    nxt          = '0;
    active_d     = active_q;
    cnt_d        = cnt_q;
    read_we      = 1'b0;
    commit_we    = 1'b0;
    edit_we      = 1'b0;
    read_idx_d   = cur_read;
    commit_idx_d = cur_commit;
    edit_idx_d   = cur_edit;
    ram_req      = '0;

    unique case (state_q)
      ST_IDLE: ;
      ST_DECODE: begin
        if (op_q == OP_READ) begin
          if (cur_read == cur_commit) begin
            load = 1'b1;
            kind = KIND_RD_EMPTY;
          end else begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = addr_of(active_q, cur_read);
          end
        end else begin
          priority if (is_alt) begin
            load = 1'b1;
            if (alt_tgt < 8'(TERMINAL_COUNT)) begin
              active_d = term_t'(alt_tgt);
              kind     = KIND_SWITCH;
            end
          end else if (key_q == KEY_NUL || key_q == KEY_HIST_UP || key_q == KEY_HIST_DN) begin
            load = 1'b1;
          end else if (key_q == KEY_CTRL_P) begin
            load = 1'b1;
            kind = KIND_DUMP;
          end else if (key_q == KEY_CTRL_U) begin
            cnt_d = '0;
            if (cur_edit == cur_commit) begin
              load = 1'b1;
              kind = KIND_ERASE;
            end else begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = addr_of(active_q, idx_dec(cur_edit));
            end
          end else if (key_q == KEY_CTRL_H || key_q == KEY_DEL) begin
            load = 1'b1;
            kind = KIND_ERASE;
            if (cur_edit != cur_commit) begin
              edit_we    = 1'b1;
              edit_idx_d = idx_dec(cur_edit);
              cnt        = 8'd1;
            end
          end else if (idx_diff(cur_edit, cur_read) >= idx_t'(RING_DEPTH)) begin
            load = 1'b1;
          end else begin
            nxt             = idx_inc(cur_edit);
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = addr_of(active_q, cur_edit);
            ram_req.wr_data = ch;
            edit_we         = 1'b1;
            edit_idx_d      = nxt;
            rdy = (ch == KEY_LF) || (ch == KEY_CTRL_D) ||
                  (idx_diff(nxt, cur_read) == idx_t'(RING_DEPTH));
            if (rdy) begin
              commit_we    = 1'b1;
              commit_idx_d = nxt;
            end
            load = 1'b1;
            kind = KIND_ECHO;
            data = ch;
          end
        end
      end
      ST_READ_WAIT: begin
        load = 1'b1;
        if (ram_rd_data == KEY_CTRL_D) begin
          kind = KIND_EOF;
          if (first_q) begin
            read_we    = 1'b1;
            read_idx_d = idx_inc(cur_read);
          end
        end else begin
          kind       = KIND_RD_BYTE;
          data       = ram_rd_data;
          read_we    = 1'b1;
          read_idx_d = idx_inc(cur_read);
        end
      end
      ST_KILL_WAIT: begin
        if (ram_rd_data == KEY_LF) begin
          load = 1'b1;
          kind = KIND_ERASE;
          cnt  = cnt_q;
        end else begin
          nxt        = idx_dec(cur_edit);
          edit_we    = 1'b1;
          edit_idx_d = nxt;
          cnt_d      = cnt_q + 8'd1;
          if (nxt == cur_commit) begin
            load = 1'b1;
            kind = KIND_ERASE;
            cnt  = cnt_q + 8'd1;
          end else begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = addr_of(active_q, idx_dec(nxt));
          end
        end
      end
      default: ;
    endcase

    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_kind_d  = out_kind_q;
    out_data_d  = out_data_q;
    out_cnt_d   = out_cnt_q;
    out_term_d  = out_term_q;
    out_rdy_d   = out_rdy_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_kind_d  = kind;
      out_data_d  = data;
      out_cnt_d   = cnt;
      out_term_d  = active_d;
      out_rdy_d   = rdy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TERMINAL_COUNT; i++) begin
        read_idx_q[i]   <= '0;
        commit_idx_q[i] <= '0;
        edit_idx_q[i]   <= '0;
      end
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      if (read_we)   read_idx_q[tsel]   <= read_idx_d;
      if (commit_we) commit_idx_q[tsel] <= commit_idx_d;
      if (edit_we)   edit_idx_q[tsel]   <= edit_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      op_q    <= op_e'(s_axis_tuser_i[0]);
      key_q   <= s_axis_tdata_i[7:0];
      first_q <= s_axis_tdata_i[8];
    end
    cnt_q      <= cnt_d;
    out_kind_q <= out_kind_d;
    out_data_q <= out_data_d;
    out_cnt_q  <= out_cnt_d;
    out_term_q <= out_term_d;
    out_rdy_q  <= out_rdy_d;
  end

  cle_line_ram u_line_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rd_data)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_rdy_q, out_term_q, out_cnt_q, out_data_q};
  assign m_axis_tuser_o  = out_kind_q;

  `CLE_ASSERT_NEXT(a_accept_decode, in_beat, state_q == ST_DECODE, "accepted beat not decoded")
  `CLE_ASSERT(a_out_free_busy, (state_q == ST_IDLE) || !out_valid_q,
              "result pending while busy")
  `CLE_ASSERT(a_kill_above_commit,
              (state_q != ST_KILL_WAIT) || (cur_edit != cur_commit),
              "kill walk crossed commit point")
  `CLE_ASSERT(a_ring_bound,
              (idx_diff(cur_edit, cur_read) <= idx_t'(RING_DEPTH)) &&
              (idx_diff(cur_commit, cur_read) <= idx_diff(cur_edit, cur_read)),
              "ring indices out of order")

endmodule
